// File: sv/linked_queue_with_free_list_macros.svh
// assertion macros for the linked queue
`ifndef LINKED_QUEUE_WITH_FREE_LIST_MACROS_SVH
`define LINKED_QUEUE_WITH_FREE_LIST_MACROS_SVH

`ifndef SYNTHESIS

`define LQFL_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("linked queue check failed");

`define LQFL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("linked queue check failed");

`else

`define LQFL_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define LQFL_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// File: sv/lqfl_pkg.sv
package lqfl_pkg;

  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic                     kind;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data_out;
    logic [STATUS_W-1:0]      status;
    logic                     is_empty;
    logic                     is_full;
  } rsp_t;

endpackage

// File: sv/lqfl_ram.sv
module lqfl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/linked_queue_with_free_list.sv
// channel | signals                      | direction | payload
// req     | req_valid, req_ready, req    | in        | req_t: kind, value
// rsp     | rsp_valid, rsp_ready, rsp    | out       | rsp_t: data_out, status, flags
//
// every word is handled in order: first the next pointer memory is read, then the
// relinked pointer is written back and the result register is loaded.
// a new word is taken only while idle and once the result register is empty or
// being drained; the block cannot take a new word before the last one is through.
// reset clears the list pointers and a fill mark; slots at or above the mark
// read as linked to their successor, so no clearing pass is needed after reset.
// a stalled rsp holds the result and blocks req until it is taken.
`include "linked_queue_with_free_list_macros.svh"

module linked_queue_with_free_list
  import lqfl_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int PW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] NIL = PW'(DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DONE = 1'b1;

  logic          st;
  logic          op_kind;
  logic          op_rej;
  logic [PW-1:0] cur;
  logic [PW-1:0] head;
  logic [PW-1:0] tail;
  logic [PW-1:0] free_head;
  logic [PW-1:0] wmark;

  logic          accept;
  logic          head_nil;
  logic          tail_nil;
  logic          fh_nil;
  logic          enq_ok;
  logic          deq_ok;
  logic          link_tail;
  logic          finish;

  logic              dat_we;
  logic              dat_re;
  logic [DATA_W-1:0] dat_rdata;
  logic              nx_we;
  logic [AW-1:0]     nx_waddr;
  logic [PW-1:0]     nx_wdata;
  logic              nx_re;
  logic [AW-1:0]     nx_raddr;
  logic [PW-1:0]     nx_rdata;

  logic [PW-1:0] succ;
  logic [PW-1:0] succ_n;
  logic          succ_nil;
  rsp_t          rsp_next;

  assign head_nil = (head >= NIL);
  assign tail_nil = (tail >= NIL);
  assign fh_nil   = (free_head >= NIL);

  assign req_ready = (st == ST_IDLE) && (!rsp_valid || rsp_ready);
  assign accept    = req_valid && req_ready;
  assign enq_ok    = accept && (req.kind == KIND_ENQ) && !fh_nil;
  assign deq_ok    = accept && (req.kind == KIND_DEQ) && !head_nil;
  assign link_tail = enq_ok && !head_nil && !tail_nil;
  assign finish    = (st == ST_DONE) && !op_rej;

  assign dat_we = enq_ok;
  assign dat_re = deq_ok;

  assign nx_re    = enq_ok || deq_ok;
  assign nx_raddr = enq_ok ? free_head[AW-1:0] : head[AW-1:0];
  assign nx_we    = link_tail || finish;
  assign nx_waddr = finish ? cur[AW-1:0] : tail[AW-1:0];
  assign nx_wdata = (finish && (op_kind == KIND_ENQ)) ? NIL : free_head;

  lqfl_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_data_ram (
    .clk   (clk),
    .we    (dat_we),
    .waddr (free_head[AW-1:0]),
    .wdata (DATA_W'(req.value)),
    .re    (dat_re),
    .raddr (head[AW-1:0]),
    .rdata (dat_rdata)
  );

  lqfl_ram #(
    .WIDTH (PW),
    .DEPTH (DEPTH)
  ) u_next_ram (
    .clk   (clk),
    .we    (nx_we),
    .waddr (nx_waddr),
    .wdata (nx_wdata),
    .re    (nx_re),
    .raddr (nx_raddr),
    .rdata (nx_rdata)
  );

  // slots at or above the fill mark still hold their reset link
  assign succ     = (cur >= wmark) ? cur + PW'(1) : nx_rdata;
  assign succ_nil = (succ >= NIL);
  assign succ_n   = succ_nil ? NIL : succ;

  always_comb begin
    rsp_next          = '0;
    rsp_next.status   = STATUS_DONE;
    rsp_next.is_empty = head_nil;
    rsp_next.is_full  = fh_nil;
    if (op_rej) begin
      rsp_next.status = (op_kind == KIND_ENQ) ? STATUS_FULL : STATUS_EMPTY;
    end else if (op_kind == KIND_ENQ) begin
      rsp_next.is_empty = 1'b0;
      rsp_next.is_full  = succ_nil;
    end else begin
      rsp_next.data_out = $signed(dat_rdata);
      rsp_next.is_empty = succ_nil;
      rsp_next.is_full  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      head      <= NIL;
      tail      <= NIL;
      free_head <= '0;
      wmark     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (st == ST_DONE) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (st)
        ST_IDLE: begin
          if (accept) begin
            st <= ST_DONE;
          end
        end
        ST_DONE: begin
          st <= ST_IDLE;
          if (finish) begin
            if (op_kind == KIND_ENQ) begin
              free_head <= succ_n;
              tail      <= cur;
              if (head_nil || tail_nil) begin
                head <= cur;
              end
              if (cur == wmark) begin
                wmark <= wmark + PW'(1);
              end
            end else begin
              head      <= succ_n;
              free_head <= cur;
              if (succ_nil) begin
                tail <= NIL;
              end
            end
          end
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind <= req.kind;
      op_rej  <= !(enq_ok || deq_ok);
      cur     <= enq_ok ? free_head : head;
    end
    if (st == ST_DONE) begin
      rsp <= rsp_next;
    end
  end

  `LQFL_ASSERT_NOW(a_ends_agree, clk, rst, 1'b1, head_nil == tail_nil)
  `LQFL_ASSERT_NOW(a_lists_apart, clk, rst, !head_nil, head != free_head)
  `LQFL_ASSERT_NEXT(a_word_lands, clk, rst, st == ST_DONE, rsp_valid && (st == ST_IDLE))
  `LQFL_ASSERT_NOW(a_mark_bound, clk, rst, 1'b1, (wmark <= NIL) && (free_head <= NIL))

endmodule
